// File: rtl/rrss_pkg.sv
// Package for the round-robin slice scheduler.
// Holds record layout, mode and status codes, and the compare-unit result type.
// No dependencies.
`timescale 1ns / 1ps

package rrss_pkg;

    // Input item modes
    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_DISPATCH = 2'd1;
    localparam logic [1:0] MODE_CLEAR    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_SLICE  = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    // One process table record
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arr;
        logic [15:0] rem;
        logic [7:0]  prio;
        logic [15:0] slc;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Compare unit decisions
    typedef struct packed {
        logic take_best;   // entry is the new admission candidate
        logic take_early;  // entry is the new earliest pending arrival
    } t_cmp_res;

endpackage

// File: rtl/rrss_if.sv
// Valid/ready channel interfaces for the scheduler input and result streams.
// Depends on nothing.
`timescale 1ns / 1ps

interface rrss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  proc_id;
    logic [15:0] arrive_at;
    logic [15:0] run_needed;
    logic [7:0]  prio_tag;
    logic [15:0] quantum;

    modport source (output valid, mode, proc_id, arrive_at, run_needed, prio_tag, quantum,
                    input ready);
    modport sink   (input valid, mode, proc_id, arrive_at, run_needed, prio_tag, quantum,
                    output ready);
endinterface

interface rrss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] seq_no;
    logic [7:0]  run_id;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [7:0]  run_prio;
    logic        finished;

    modport source (output valid, status, seq_no, run_id, start_time, end_time, run_prio,
                    finished, input ready);
    modport sink   (input valid, status, seq_no, run_id, start_time, end_time, run_prio,
                    finished, output ready);
endinterface

// File: rtl/rrss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rrss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/rrss_cmp.sv
// Shared compare unit used on every table scan step.
// Decides admission candidate and earliest pending arrival. Depends on rrss_pkg.
`timescale 1ns / 1ps

module rrss_cmp (
    input  logic            i_pend,
    input  logic [15:0]     i_arr,
    input  logic [7:0]      i_id,
    input  logic [31:0]     i_now,
    input  logic            i_found,
    input  logic [15:0]     i_best_arr,
    input  logic [7:0]      i_best_id,
    input  logic            i_any,
    input  logic [15:0]     i_early,
    output rrss_pkg::t_cmp_res o_res
);
    import rrss_pkg::*;

    logic arrived;
    logic better;

    // Eligible when pending and arrived; ordered by (arrival, id), first index wins ties
    always_comb begin
        arrived = ({16'd0, i_arr} <= i_now);
        better  = (i_arr < i_best_arr) || ((i_arr == i_best_arr) && (i_id < i_best_id));
        o_res.take_best  = i_pend && arrived && (!i_found || better);
        o_res.take_early = i_pend && (!i_any || (i_arr < i_early));
    end
endmodule

// File: rtl/round_robin_slice_scheduler_core.sv
// Top level of the round-robin slice scheduler: sequencer, table and ring RAMs.
// Depends on rrss_pkg, rrss_if, rrss_ram, rrss_cmp.
//
//  channel | dir | handshake          | payload
//  i_in    | in  | valid/ready        | mode, proc_id, arrive_at, run_needed, prio_tag, quantum
//  o_out   | out | valid/ready        | status, seq_no, run_id, start_time, end_time, ...
//
// A load passes through S_EMIT, which waits for a free output register; a clear emits no result.
// A dispatch runs one table scan per admitted process plus one that finds none,
// before the slice, again after a time jump and again after the slice; each
// scan visits S_SC_RD and S_SC_CMP per loaded entry through the single table read
// port and the compare unit; S_RING_RD, S_TAB_RD and S_RUN fetch and run the ring head.
// Reset is synchronous, active low; it empties table, ring, time and sequence.
// One item is in work at a time; the result register decouples the output stall.
`timescale 1ns / 1ps

module round_robin_slice_scheduler_core #(
    parameter int MAX_PROCS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrss_in_if.sink    i_in,
    rrss_out_if.source o_out
);
    import rrss_pkg::*;

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_PROCS);
    localparam logic [CW:0]   MAXW = (CW + 1)'(MAX_PROCS);
    localparam logic [IW-1:0] LAST = IW'(MAX_PROCS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SC_RD, S_SC_CMP, S_SC_END, S_RING_RD, S_TAB_RD, S_RUN, S_EMIT
    } t_state;

    t_state r_state;

    // Scheduler state
    logic [MAX_PROCS-1:0] r_pend;
    logic [IW-1:0]  r_head;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_loaded;
    logic [31:0]    r_now;
    logic [15:0]    r_seq;

    // Scan state
    logic [CW-1:0]  r_i;
    logic           r_found;
    logic [IW-1:0]  r_best;
    logic [15:0]    r_best_arr;
    logic [7:0]     r_best_id;
    logic           r_any;
    logic [15:0]    r_early;
    logic           r_jumped;
    logic           r_post;
    logic [IW-1:0]  r_idx;
    logic           r_done;

    // Pending result and output register
    logic [1:0]  r_res_status, r_out_status;
    logic [15:0] r_res_seq, r_out_seq;
    logic [7:0]  r_res_id, r_out_id;
    logic [31:0] r_res_start, r_out_start;
    logic [31:0] r_res_end, r_out_end;
    logic [7:0]  r_res_prio, r_out_prio;
    logic        r_res_fin, r_out_fin;
    logic        r_out_valid;

    // RAM ports
    logic          tab_we;
    logic [IW-1:0] tab_waddr, tab_raddr;
    t_rec          tab_wdata, tab_rdata;
    logic          ring_we;
    logic [IW-1:0] ring_waddr;
    logic [IW-1:0] ring_rdata;

    t_cmp_res cmp;
    logic [CW:0]   tail_sum;
    logic [IW-1:0] tail;
    logic [15:0]   slc_eff;
    logic          run_fin;
    logic [15:0]   run_len;
    logic          accept;
    logic          out_free;

    rrss_ram #(.WIDTH(REC_W), .DEPTH(MAX_PROCS)) u_tab (
        .i_clk  (i_clk),
        .i_we   (tab_we),
        .i_waddr(tab_waddr),
        .i_wdata(tab_wdata),
        .i_raddr(tab_raddr),
        .o_rdata(tab_rdata)
    );

    rrss_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_ring (
        .i_clk  (i_clk),
        .i_we   (ring_we),
        .i_waddr(ring_waddr),
        .i_wdata(r_state == S_SC_END && r_post && !r_found ? r_idx : r_best),
        .i_raddr(r_head),
        .o_rdata(ring_rdata)
    );

    rrss_cmp u_cmp (
        .i_pend    (r_pend[r_i[IW-1:0]]),
        .i_arr     (tab_rdata.arr),
        .i_id      (tab_rdata.id),
        .i_now     (r_now),
        .i_found   (r_found),
        .i_best_arr(r_best_arr),
        .i_best_id (r_best_id),
        .i_any     (r_any),
        .i_early   (r_early),
        .o_res     (cmp)
    );

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Ring tail and slice arithmetic
    always_comb begin
        tail_sum = {1'b0, CW'(r_head)} + {1'b0, r_count};
        if (tail_sum >= MAXW) begin
            tail_sum = tail_sum - MAXW;
        end
        tail    = tail_sum[IW-1:0];
        slc_eff = (tab_rdata.slc == 16'd0) ? 16'd1 : tab_rdata.slc;
        run_fin = (tab_rdata.rem <= slc_eff);
        run_len = run_fin ? tab_rdata.rem : slc_eff;
    end

    // RAM port control
    always_comb begin
        tab_we     = 1'b0;
        tab_waddr  = r_idx;
        tab_wdata  = tab_rdata;
        tab_raddr  = r_i[IW-1:0];
        ring_we    = 1'b0;
        ring_waddr = tail;
        case (r_state)
            S_IDLE: begin
                tab_waddr = r_loaded[IW-1:0];
                tab_wdata = '{id: i_in.proc_id, arr: i_in.arrive_at, rem: i_in.run_needed,
                              prio: i_in.prio_tag, slc: i_in.quantum};
                tab_we    = accept && (i_in.mode == MODE_LOAD) && (r_loaded != MAXC);
            end
            S_TAB_RD: begin
                tab_raddr = ring_rdata;
            end
            S_RUN: begin
                tab_we        = 1'b1;
                tab_wdata.rem = run_fin ? 16'd0 : (tab_rdata.rem - run_len);
            end
            S_SC_END: begin
                if (r_count < MAXC) begin
                    ring_we = r_found || (r_post && !r_done);
                end
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_loaded    <= '0;
            r_now       <= '0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_found     <= 1'b0;
            r_any       <= 1'b0;
            r_jumped    <= 1'b0;
            r_post      <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_status <= ST_LOADED;
                        r_res_seq    <= '0;
                        r_res_id     <= '0;
                        r_res_start  <= '0;
                        r_res_end    <= '0;
                        r_res_prio   <= '0;
                        r_res_fin    <= 1'b0;
                        r_i          <= '0;
                        r_found      <= 1'b0;
                        r_any        <= 1'b0;
                        r_jumped     <= 1'b0;
                        r_post       <= 1'b0;
                        case (i_in.mode)
                            MODE_LOAD: begin
                                if (r_loaded == MAXC) begin
                                    r_res_status <= ST_FULL;
                                end else begin
                                    r_pend[r_loaded[IW-1:0]] <= 1'b1;
                                    r_loaded <= r_loaded + 1'b1;
                                end
                                r_state <= S_EMIT;
                            end
                            MODE_DISPATCH: begin
                                r_state <= S_SC_RD;
                            end
                            MODE_CLEAR: begin
                                r_pend   <= '0;
                                r_head   <= '0;
                                r_count  <= '0;
                                r_loaded <= '0;
                                r_now    <= '0;
                                r_seq    <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // Walk the loaded entries one per read
                S_SC_RD: begin
                    r_state <= (r_i == r_loaded) ? S_SC_END : S_SC_CMP;
                end
                S_SC_CMP: begin
                    if (cmp.take_best) begin
                        r_found    <= 1'b1;
                        r_best     <= r_i[IW-1:0];
                        r_best_arr <= tab_rdata.arr;
                        r_best_id  <= tab_rdata.id;
                    end
                    if (cmp.take_early) begin
                        r_any   <= 1'b1;
                        r_early <= tab_rdata.arr;
                    end
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SC_RD;
                end
                S_SC_END: begin
                    r_i     <= '0;
                    r_found <= 1'b0;
                    r_any   <= 1'b0;
                    if (r_found) begin
                        // admit the winner, then rescan
                        r_pend[r_best] <= 1'b0;
                        if (r_count < MAXC) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_SC_RD;
                    end else if (r_post) begin
                        // requeue a preempted process behind the new arrivals
                        if (!r_done && (r_count < MAXC)) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_EMIT;
                    end else if (r_count != '0) begin
                        r_state <= S_RING_RD;
                    end else if (!r_any || r_jumped) begin
                        r_res_status <= ST_DONE;
                        r_state      <= S_EMIT;
                    end else begin
                        // idle ring: jump time to the earliest arrival
                        if ({16'd0, r_early} > r_now) begin
                            r_now <= {16'd0, r_early};
                        end
                        r_jumped <= 1'b1;
                        r_state  <= S_SC_RD;
                    end
                end
                S_RING_RD: begin
                    r_state <= S_TAB_RD;
                end
                S_TAB_RD: begin
                    r_idx   <= ring_rdata;
                    r_state <= S_RUN;
                end
                // Run the head process for one slice
                S_RUN: begin
                    r_res_status <= ST_SLICE;
                    r_res_seq    <= r_seq + 16'd1;
                    r_res_id     <= tab_rdata.id;
                    r_res_start  <= r_now;
                    r_res_end    <= r_now + {16'd0, run_len};
                    r_res_prio   <= tab_rdata.prio;
                    r_res_fin    <= run_fin;
                    r_done       <= run_fin;
                    r_seq        <= r_seq + 16'd1;
                    r_now        <= r_now + {16'd0, run_len};
                    r_head       <= (r_head == LAST) ? '0 : r_head + 1'b1;
                    r_count      <= r_count - 1'b1;
                    r_post       <= 1'b1;
                    r_state      <= S_SC_RD;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_seq    <= r_res_seq;
                        r_out_id     <= r_res_id;
                        r_out_start  <= r_res_start;
                        r_out_end    <= r_res_end;
                        r_out_prio   <= r_res_prio;
                        r_out_fin    <= r_res_fin;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.seq_no     = r_out_seq;
    assign o_out.run_id     = r_out_id;
    assign o_out.start_time = r_out_start;
    assign o_out.end_time   = r_out_end;
    assign o_out.run_prio   = r_out_prio;
    assign o_out.finished   = r_out_fin;
endmodule
